/* sv/esdf_pkg.sv */
// Package for the escape byte-stuffing deframer: marker bytes, event codes,
// the result record and default sizes. No dependencies.
package esdf_pkg;

  localparam int BufferBytesDefault = 256;

  localparam logic [7:0] CH_START = 8'h53;  // 'S'
  localparam logic [7:0] CH_END   = 8'h45;  // 'E'
  localparam logic [7:0] CH_ESC   = 8'h2F;  // '/'

  localparam int IndexWidth  = 8;
  localparam int LengthWidth = 9;

  typedef enum logic [2:0] {
    EV_DATA      = 3'd0,
    EV_ESC       = 3'd1,
    EV_START     = 3'd2,
    EV_END       = 3'd3,
    EV_DISCARD   = 3'd4,
    EV_MALFORMED = 3'd5
  } event_t;

  typedef struct packed {
    logic                   synced;
    logic                   overflow;
    event_t                 event_res;
    logic [LengthWidth-1:0] frame_length;
    logic                   frame_done;
    logic [IndexWidth-1:0]  data_index;
    logic [7:0]             data_byte;
    logic                   data_valid;
  } result_t;

endpackage

/* sv/esdf_decode.sv */
// Per-byte decision logic and the receiver state (sync, write count, escape).
// Depends on esdf_pkg.
module esdf_decode #(
  parameter int BUFFER_BYTES = esdf_pkg::BufferBytesDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output esdf_pkg::result_t result
);

  localparam int CountWidth = $clog2(BUFFER_BYTES + 1);
  localparam logic [CountWidth-1:0] BufLimit = CountWidth'(BUFFER_BYTES);

  logic                  in_sync, in_sync_next;
  logic [CountWidth-1:0] write_count, write_count_next;
  logic                  escape_pending, escape_pending_next;

  logic                  full;
  logic                  sync_eff;
  logic                  store;
  esdf_pkg::event_t      ev;
  logic [CountWidth+8:0] count_wide;

  assign full       = (write_count >= BufLimit);
  assign sync_eff   = in_sync & ~full;
  assign count_wide = {9'd0, write_count};

  always_comb begin
    in_sync_next        = sync_eff;
    write_count_next    = write_count;
    escape_pending_next = escape_pending;
    store               = 1'b0;
    ev                  = esdf_pkg::EV_DATA;
    if (!sync_eff) begin
      if (rx_byte == esdf_pkg::CH_START) begin
        in_sync_next        = 1'b1;
        write_count_next    = '0;
        escape_pending_next = 1'b0;
        ev                  = esdf_pkg::EV_START;
      end else begin
        ev = esdf_pkg::EV_DISCARD;
      end
    end else if (escape_pending) begin
      // An escape prefix makes the three special bytes plain data; any other
      // byte after it is a broken escape and drops sync.
      escape_pending_next = 1'b0;
      if (rx_byte == esdf_pkg::CH_START || rx_byte == esdf_pkg::CH_END ||
          rx_byte == esdf_pkg::CH_ESC) begin
        store = 1'b1;
      end else begin
        in_sync_next     = 1'b0;
        write_count_next = '0;
        ev               = esdf_pkg::EV_MALFORMED;
      end
    end else if (rx_byte == esdf_pkg::CH_START) begin
      write_count_next = '0;
      ev               = esdf_pkg::EV_START;
    end else if (rx_byte == esdf_pkg::CH_END) begin
      ev = esdf_pkg::EV_END;
    end else if (rx_byte == esdf_pkg::CH_ESC) begin
      escape_pending_next = 1'b1;
      ev                  = esdf_pkg::EV_ESC;
    end else begin
      store = 1'b1;
    end
    if (store) begin
      write_count_next = write_count + CountWidth'(1);
    end

    result.data_valid   = store;
    result.data_byte    = store ? rx_byte : 8'd0;
    result.data_index   = store ? count_wide[esdf_pkg::IndexWidth-1:0] : '0;
    result.frame_done   = (ev == esdf_pkg::EV_END);
    result.frame_length = (ev == esdf_pkg::EV_END) ?
                          count_wide[esdf_pkg::LengthWidth-1:0] : '0;
    result.event_res    = ev;
    result.overflow     = full;
    result.synced       = in_sync_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sync        <= 1'b0;
      write_count    <= '0;
      escape_pending <= 1'b0;
    end else if (accept) begin
      in_sync        <= in_sync_next;
      write_count    <= write_count_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

/* sv/esdf_out_buf.sv */
// Two-entry output buffer (result register plus skid register) for results.
// Depends on esdf_pkg.
module esdf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  esdf_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output esdf_pkg::result_t out_data
);

  logic              skid_valid;
  esdf_pkg::result_t skid_data;
  logic              push;
  logic              pop;

  assign in_ready = ~skid_valid;
  assign push     = in_valid & in_ready;
  assign pop      = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

/* sv/escape_byte_stuffing_deframer_top.sv */
// Top level of the escape byte-stuffing deframer: decision logic feeding a
// two-entry result buffer. Depends on esdf_pkg, esdf_decode, esdf_out_buf.
//
//   Channel   Direction  Carries
//   s_axis    in         one received link byte per request
//   m_axis    out        one result per request: payload byte, index, status
//
// Every accepted byte yields exactly one result. It shows on m_axis in the cycle
// after acceptance unless the result register still holds a stalled result, in
// which case it waits in the skid entry. A byte can be accepted every cycle;
// the only limit is the downstream side, since the result register plus one
// skid entry hold at most two results.
// Reset (rst, synchronous) drops sync, clears the write count and escape flag,
// and empties both buffer entries. When m_axis stalls, the skid entry fills and
// s_axis_tready falls on the next cycle until a result is taken.
module escape_byte_stuffing_deframer_top #(
  parameter int BUFFER_BYTES = esdf_pkg::BufferBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] data_valid, [8:1] data_byte, [16:9] data_index, [25:17] frame_length,
  // [26] overflow, [27] synced, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_done
  output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

  logic              accept;
  esdf_pkg::result_t decoded;
  esdf_pkg::result_t held;

  // The receiver state advances only on an accepted request.
  assign accept = s_axis_tvalid & s_axis_tready;

  esdf_decode #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .rx_byte(s_axis_tdata),
    .result (decoded)
  );

  esdf_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (decoded),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (held)
  );

  // Pack the result fields onto the stream bus, lowest field in the lowest bits.
  assign m_axis_tdata = {4'd0, held.synced, held.overflow, held.frame_length,
                         held.data_index, held.data_byte, held.data_valid};
  assign m_axis_tlast = held.frame_done;
  assign m_axis_tuser = held.event_res;

endmodule

/* verif/deframer_checker.sv */
// Checker for the escape byte-stuffing deframer: watches both stream channels,
// predicts one result per accepted link byte and compares. Depends on esdf_pkg.
`timescale 1ns / 1ps

module deframer_checker #(
  parameter int BUFFER_BYTES = esdf_pkg::BufferBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic [2:0]  m_tuser,
  output int          failures,
  output int          pending
);

  // Deframer state as the predictor sees it.
  logic        in_frame;
  int unsigned fill_count;
  logic        escape_armed;

  esdf_pkg::result_t expected_results[$];
  int                bytes_taken;
  int                results_seen;
  int                bad_results;

  assign pending  = bytes_taken - results_seen;
  assign failures = bad_results;

  function automatic esdf_pkg::result_t deframe_byte(input logic [7:0] c);
    esdf_pkg::result_t r;
    logic              keep;
    r = '0;
    r.event_res = esdf_pkg::EV_DATA;
    keep = 1'b0;
    if (fill_count >= BUFFER_BYTES) begin
      in_frame = 1'b0;
      r.overflow = 1'b1;
    end
    if (!in_frame) begin
      // Out of sync only a start marker matters; the escape flag is left alone.
      if (c == esdf_pkg::CH_START) begin
        in_frame = 1'b1;
        fill_count = 0;
        escape_armed = 1'b0;
        r.event_res = esdf_pkg::EV_START;
      end else begin
        r.event_res = esdf_pkg::EV_DISCARD;
      end
    end else if (c == esdf_pkg::CH_START || c == esdf_pkg::CH_END ||
                 c == esdf_pkg::CH_ESC) begin
      if (escape_armed) begin
        escape_armed = 1'b0;
        keep = 1'b1;
      end else if (c == esdf_pkg::CH_START) begin
        fill_count = 0;
        r.event_res = esdf_pkg::EV_START;
      end else if (c == esdf_pkg::CH_END) begin
        // The count is reported but kept, so later bytes append.
        r.frame_done = 1'b1;
        r.frame_length = fill_count[esdf_pkg::LengthWidth-1:0];
        r.event_res = esdf_pkg::EV_END;
      end else begin
        escape_armed = 1'b1;
        r.event_res = esdf_pkg::EV_ESC;
      end
    end else if (escape_armed) begin
      in_frame = 1'b0;
      fill_count = 0;
      escape_armed = 1'b0;
      r.event_res = esdf_pkg::EV_MALFORMED;
    end else begin
      keep = 1'b1;
    end
    if (keep) begin
      r.data_valid = 1'b1;
      r.data_byte = c;
      r.data_index = fill_count[esdf_pkg::IndexWidth-1:0];
      fill_count = fill_count + 1;
    end
    r.synced = in_frame;
    return r;
  endfunction

  function automatic string show(input esdf_pkg::result_t r);
    return $sformatf("dv=%0d byte=%02h idx=%0d done=%0d len=%0d ev=%s ovf=%0d sync=%0d",
                     r.data_valid, r.data_byte, r.data_index, r.frame_done,
                     r.frame_length, r.event_res.name(), r.overflow, r.synced);
  endfunction

  always @(posedge clk) begin
    esdf_pkg::result_t seen;
    esdf_pkg::result_t want;
    if (rst) begin
      in_frame = 1'b0;
      fill_count = 0;
      escape_armed = 1'b0;
      expected_results.delete();
      bytes_taken = 0;
      results_seen = 0;
      bad_results = 0;
    end else begin
      // Results leave in the cycle after their request at the earliest, so the
      // outgoing side is checked before this edge's request is predicted.
      if (m_tvalid && m_tready) begin
        results_seen = results_seen + 1;
        seen.data_valid   = m_tdata[0];
        seen.data_byte    = m_tdata[8:1];
        seen.data_index   = m_tdata[16:9];
        seen.frame_length = m_tdata[25:17];
        seen.overflow     = m_tdata[26];
        seen.synced       = m_tdata[27];
        seen.frame_done   = m_tlast;
        seen.event_res    = esdf_pkg::event_t'(m_tuser);
        if (expected_results.size() == 0) begin
          bad_results = bad_results + 1;
          if (bad_results <= 10) $display("unexpected result: %s", show(seen));
        end else begin
          want = expected_results.pop_front();
          if (seen !== want || m_tdata[31:28] !== 4'd0) begin
            bad_results = bad_results + 1;
            if (bad_results <= 10) begin
              $display("mismatch at result %0d (pad %h)", results_seen, m_tdata[31:28]);
              $display("  expected: %s", show(want));
              $display("  actual:   %s", show(seen));
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_taken = bytes_taken + 1;
        expected_results.push_back(deframe_byte(s_tdata));
      end
    end
  end

endmodule

/* verif/tb_top.sv */
// Top of the deframer testbench: clock, reset, link byte stimulus and result
// back-pressure. Depends on esdf_pkg, the deframer top and deframer_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int BufferBytes = esdf_pkg::BufferBytesDefault;
  localparam int RandomBytes = 800;
  // Roughly a thousand requests with stalls from the worst receiver mode,
  // taken many times over.
  localparam int CycleLimit  = 300000;

  // Receiver back-pressure patterns, switched every so often.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  int failures;
  int pending;

  always #5 clk = ~clk;

  escape_byte_stuffing_deframer_top #(
    .BUFFER_BYTES(BufferBytes)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  deframer_checker #(
    .BUFFER_BYTES(BufferBytes)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .s_tdata (s_axis_tdata),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata (m_axis_tdata),
    .m_tlast (m_axis_tlast),
    .m_tuser (m_axis_tuser),
    .failures(failures),
    .pending (pending)
  );

  // The receiver draws its stall pattern at random from the four modes. The free
  // mode gives long stretches of full throughput; the heavy mode keeps the skid
  // entry full so that s_axis_tready drops often.
  rx_mode_t rx_mode = RX_FREE;
  int       rx_cycle = 0;

  always @(negedge clk) begin
    if (rx_cycle % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:     m_axis_tready <= 1'b1;
      RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= (rx_cycle % 5 >= 2);
    endcase
    rx_cycle = rx_cycle + 1;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  int burst_left = 0;
  // Every link byte that has been sent, escape prefixes and noise included.
  int sent_count = 0;

  // Sends one link byte as a request. All driving happens at the falling edge.
  // The sender works in bursts; between bursts tvalid is held low for a random
  // gap, and some bursts follow each other with no gap at all. tvalid is only
  // lowered and raised again on different falling edges.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    end
    burst_left = burst_left - 1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent_count = sent_count + 1;
    @(negedge clk);
  endtask

  // A payload byte that collides with a marker goes out behind an escape.
  task automatic send_payload(input logic [7:0] b);
    if (b == esdf_pkg::CH_START || b == esdf_pkg::CH_END || b == esdf_pkg::CH_ESC) begin
      send_byte(esdf_pkg::CH_ESC);
    end
    send_byte(b);
  endtask

  // Holds the sender off until every expected result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_payload();
    case ($urandom_range(0, 7))
      0:       return esdf_pkg::CH_START;
      1:       return esdf_pkg::CH_END;
      2:       return esdf_pkg::CH_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == esdf_pkg::CH_START || b == esdf_pkg::CH_END || b == esdf_pkg::CH_ESC) begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // One frame: start marker, escaped payload, usually a closing end marker.
  // Now and then a bare end marker inside the frame reports a partial length
  // and the frame carries on, or a bad escape breaks the frame. Long frames
  // store every payload byte, so they run the buffer full and reach the
  // overflow path.
  task automatic send_frame(input int payload_len, input logic long_frame);
    int  k;
    int  roll;
    logic broken;
    broken = 1'b0;
    send_byte(esdf_pkg::CH_START);
    for (k = 0; k < payload_len && !broken; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3 && !long_frame) begin
        send_byte(esdf_pkg::CH_END);
      end else if (roll < 6 && !long_frame) begin
        send_byte(esdf_pkg::CH_ESC);
        send_byte(plain_byte());
        broken = 1'b1;
      end else begin
        send_payload(random_payload());
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      send_byte(esdf_pkg::CH_END);
    end
  endtask

  initial begin
    int       frame_no;
    int       n;
    logic     held_once;
    frame_no = 0;
    held_once = 1'b0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Out of sync: an end marker, both byte extremes and a
    // lone escape are all thrown away.
    send_byte(esdf_pkg::CH_END);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(esdf_pkg::CH_ESC);
    // Sync, then data extremes and every marker escaped as data.
    send_byte(esdf_pkg::CH_START);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_payload(esdf_pkg::CH_START);
    send_payload(esdf_pkg::CH_END);
    send_payload(esdf_pkg::CH_ESC);
    // Frame end reports five bytes; the next byte appends at index five.
    send_byte(esdf_pkg::CH_END);
    send_byte(8'h41);
    // A bare start marker restarts the frame in place.
    send_byte(esdf_pkg::CH_START);
    // Escape followed by an ordinary byte drops sync; the next byte is lost.
    send_byte(esdf_pkg::CH_ESC);
    send_byte(8'h41);
    send_byte(8'h41);
    // Resync and close an empty-then-one-byte frame.
    send_byte(esdf_pkg::CH_START);
    send_byte(esdf_pkg::CH_END);
    send_payload(esdf_pkg::CH_START);
    send_byte(esdf_pkg::CH_END);

    drain_results();

    // Random part: mostly well-formed frames with random content, some
    // line noise in between. Two frames are long enough to overflow.
    while (sent_count < RandomBytes) begin
      if (sent_count >= RandomBytes / 2 && !held_once) begin
        drain_results();
        held_once = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
          else send_byte(random_payload());
        end
      end else begin
        frame_no = frame_no + 1;
        if (frame_no == 3 || frame_no == 20) begin
          send_frame($urandom_range(BufferBytes, BufferBytes + 6), 1'b1);
        end else begin
          send_frame($urandom_range(0, 12), 1'b0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
